// ===== rtl/core/nlqt_pkg.sv =====
// Shared types and constants for the neighbor link quality table.
package nlqt_pkg;

    localparam logic [15:0] NULL_SHORT_ID = 16'hFFFF;

    // Entry index as carried down the chain; covers the largest table size
    localparam int IDX_W = 8;

    // Configuration register indexes
    localparam logic [7:0] CFG_OWN_NODE_ID        = 8'd0;
    localparam logic [7:0] CFG_UPDATES_ENABLED    = 8'd1;
    localparam logic [7:0] CFG_TRACK_EUI          = 8'd2;
    localparam logic [7:0] CFG_REPORT_DESTINATION = 8'd3;

    typedef enum logic {
        OP_PACKET = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_RECORDED = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4
    } status_t;

    // One item as it travels along the row of entry cells. Once an item is
    // resolved, sender/lqi/rssi/eui hold the contents of the entry it touched.
    typedef struct packed {
        op_t               op;
        logic [15:0]       sender;
        logic              addr_rsp;
        logic [7:0]        lqi;
        logic signed [7:0] rssi;
        logic [63:0]       eui;
        logic              done;
        status_t           status;
        logic [IDX_W-1:0]  idx;
    } item_t;

endpackage

// ===== rtl/core/neighbor_link_quality_table.sv =====
// Top level of the neighbor link quality table: config registers, cell row, result port.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item per transfer: a packet
//   observation (opcode 0) or a lookup by 64-bit address (opcode 1).
//   Output channel (out_valid/out_ready) returns exactly one result per item,
//   in input order.
//   Config channel (cfg_valid/cfg_ready) writes one register per transfer;
//   cfg_ready is always high. Write only while no item is in flight.
//   Each table entry is a cell in a row; an item moves one cell per cycle
//   while the row advances and is compared against that cell's entry on the
//   way. out_valid comes from the last cell's item register, so the item
//   passes every cell's register before its result. A new item can be taken
//   every cycle while the row is not held, since each item sees the entries
//   after all earlier items have passed them.
//   When out_ready is low with a result waiting, the whole row holds and
//   in_ready drops until the result is taken.
//   Reset empties every entry at once (no clearing pass), clears config to
//   its reset values (track_eui set) and empties the row.
module neighbor_link_quality_table
    import nlqt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [15:0]        sender_id,
    input  logic               is_mgmt_packet,
    input  logic               is_addr_response,
    input  logic [7:0]         link_quality,
    input  logic signed [7:0]  signal_strength,
    input  logic [63:0]        long_address,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [3:0]         entry_index,
    output logic [15:0]        entry_short_id,
    output logic [7:0]         entry_lqi,
    output logic signed [7:0]  entry_rssi,
    output logic [63:0]        entry_eui,
    output logic               request_eui,
    output logic               send_update,
    output logic [15:0]        send_to
);

    logic [15:0] own_node_id_reg;
    logic        updates_enabled_reg;
    logic        track_eui_reg;
    logic [15:0] report_destination_reg;

    logic        advance;
    item_t       entry_item;
    logic        ignore_pkt;

    logic        chain_valid [TABLE_ENTRIES];
    item_t       chain_item  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] used;

    item_t       tail;
    status_t     final_status;
    logic        show;

    // Configuration writes; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_id_reg        <= '0;
            updates_enabled_reg    <= 1'b0;
            track_eui_reg          <= 1'b1;
            report_destination_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OWN_NODE_ID:        own_node_id_reg        <= cfg_data;
                CFG_UPDATES_ENABLED:    updates_enabled_reg    <= cfg_data[0];
                CFG_TRACK_EUI:          track_eui_reg          <= cfg_data[0];
                CFG_REPORT_DESTINATION: report_destination_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Advance the whole row unless a result is waiting on a stalled receiver
    assign advance  = !chain_valid[TABLE_ENTRIES-1] || out_ready;
    assign in_ready = advance;

    // Screen out packets that are never recorded before they enter the row
    always_comb
    begin
        ignore_pkt = (op_t'(opcode) == OP_PACKET)
                     && (!is_mgmt_packet || (sender_id == own_node_id_reg)
                         || (sender_id == NULL_SHORT_ID));

        entry_item.op       = op_t'(opcode);
        entry_item.sender   = sender_id;
        entry_item.addr_rsp = is_addr_response;
        entry_item.lqi      = link_quality;
        entry_item.rssi     = signal_strength;
        entry_item.eui      = long_address;
        entry_item.done     = ignore_pkt;
        entry_item.status   = ST_IGNORED;
        entry_item.idx      = '0;
    end

    // Row of entry cells
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        logic  up_valid;
        item_t up_item;

        if (i == 0)
        begin : g_head
            assign up_valid = in_valid;
            assign up_item  = entry_item;
        end
        else
        begin : g_link
            assign up_valid = chain_valid[i-1];
            assign up_item  = chain_item[i-1];
        end

        nlqt_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .track_eui  (track_eui_reg),
            .up_valid   (up_valid),
            .up_item    (up_item),
            .down_valid (chain_valid[i]),
            .down_item  (chain_item[i]),
            .used       (used[i])
        );
    end

    // Format the result from the last cell's register
    assign tail = chain_item[TABLE_ENTRIES-1];

    always_comb
    begin
        if (tail.done)
        begin
            final_status = tail.status;
        end
        else if (tail.op == OP_LOOKUP)
        begin
            final_status = ST_MISS;
        end
        else
        begin
            final_status = ST_FULL;
        end
        show = (final_status == ST_RECORDED) || (final_status == ST_HIT);
    end

    assign out_valid      = chain_valid[TABLE_ENTRIES-1];
    assign status         = final_status;
    assign entry_index    = show ? tail.idx[3:0] : 4'd0;
    assign entry_short_id = show ? tail.sender   : 16'd0;
    assign entry_lqi      = show ? tail.lqi      : 8'd0;
    assign entry_rssi     = show ? tail.rssi     : 8'sd0;
    assign entry_eui      = show ? tail.eui      : 64'd0;
    assign request_eui    = (final_status == ST_RECORDED) && (tail.eui == 64'd0);
    assign send_update    = (final_status == ST_RECORDED) && updates_enabled_reg;
    assign send_to        = report_destination_reg;

    // Entries fill from the lowest index and are never freed
    a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (used & (used + 1'b1)) == '0)
        else $error("occupied entries do not form a prefix");

    // A full report only when every entry is occupied
    a_full_means_all_used: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (final_status == ST_FULL)) |-> (&used))
        else $error("table full reported with a free entry");

    // A recorded entry never holds the null short address
    a_recorded_not_null: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (final_status == ST_RECORDED)) |-> (entry_short_id != NULL_SHORT_ID))
        else $error("recorded entry carries the null short address");

    // A stalled row keeps the occupancy unchanged
    a_stall_holds_table: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(used))
        else $error("table changed while the row was stalled");

endmodule

// ===== rtl/core/nlqt_cell.sv =====
// One table entry with its compare logic and the item register to the next cell.
module nlqt_cell
    import nlqt_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  logic  track_eui,
    input  logic  up_valid,
    input  item_t up_item,
    output logic  down_valid,
    output item_t down_item,
    output logic  used
);

    logic [15:0]       id_reg;
    logic [7:0]        lqi_reg;
    logic signed [7:0] rssi_reg;
    logic [63:0]       eui_reg;
    logic              valid_reg;
    item_t             item_reg;
    item_t             item_next;

    logic              claim;
    logic              lookup_hit;
    logic [63:0]       eui_new;

    assign used = (id_reg != NULL_SHORT_ID);

    // Decide whether the passing item resolves at this entry
    always_comb
    begin
        claim      = !up_item.done && (up_item.op == OP_PACKET)
                     && (!used || (id_reg == up_item.sender));
        lookup_hit = !up_item.done && (up_item.op == OP_LOOKUP)
                     && used && (eui_reg == up_item.eui);
        eui_new    = (track_eui && up_item.addr_rsp) ? up_item.eui : eui_reg;

        item_next = up_item;
        if (claim)
        begin
            item_next.done   = 1'b1;
            item_next.status = ST_RECORDED;
            item_next.idx    = IDX_W'(CELL_INDEX);
            item_next.eui    = eui_new;
        end
        else if (lookup_hit)
        begin
            item_next.done   = 1'b1;
            item_next.status = ST_HIT;
            item_next.idx    = IDX_W'(CELL_INDEX);
            item_next.sender = id_reg;
            item_next.lqi    = lqi_reg;
            item_next.rssi   = rssi_reg;
        end
    end

    // Update the entry on a claimed packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg   <= NULL_SHORT_ID;
            lqi_reg  <= '0;
            rssi_reg <= '0;
            eui_reg  <= '0;
        end
        else if (advance && up_valid && claim)
        begin
            id_reg   <= up_item.sender;
            lqi_reg  <= up_item.lqi;
            rssi_reg <= up_item.rssi;
            eui_reg  <= eui_new;
        end
    end

    // Hand the item to the next cell; hold while the chain is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_item  = item_reg;

endmodule

// ===== tb/neighbor_link_quality_table_tb.sv =====
// Self-checking testbench for the neighbor link quality table: scoreboard class and drivers.
`timescale 1ns / 1ps

module neighbor_link_quality_table_tb
    import nlqt_pkg::*;
();

    localparam int NUM_ENTRIES = 16;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int HOLD_AT_A = 300;
    localparam int HOLD_AT_B = 800;
    localparam int MAX_REPORTS = 10;
    localparam logic [7:0] CFG_FIRST_UNUSED = CFG_REPORT_DESTINATION + 8'd1;

    // Table model: shadow registers, entries and the queue of expected results
    class link_table_scoreboard_t #(int ENTRIES = 16);
        typedef struct packed {
            logic [2:0]        status;
            logic [3:0]        index;
            logic [15:0]       short_id;
            logic [7:0]        lqi;
            logic signed [7:0] rssi;
            logic [63:0]       eui;
            logic              req;
            logic              upd;
            logic [15:0]       dest;
        } nbr_result_t;

        logic [15:0]       own_id;
        logic              upd_en;
        logic              track;
        logic [15:0]       dest;
        logic [15:0]       tbl_id [ENTRIES];
        logic [7:0]        tbl_lqi [ENTRIES];
        logic signed [7:0] tbl_rssi [ENTRIES];
        logic [63:0]       tbl_eui [ENTRIES];
        nbr_result_t       expected_results [$];
        int                mismatches;
        int                checked;
        int                status_seen [5];

        function new();
            int i;
            own_id = '0;
            upd_en = 1'b0;
            track = 1'b1;
            dest = '0;
            for (i = 0; i < ENTRIES; i++)
            begin
                tbl_id[i] = NULL_SHORT_ID;
                tbl_lqi[i] = '0;
                tbl_rssi[i] = '0;
                tbl_eui[i] = '0;
            end
            for (i = 0; i < 5; i++)
            begin
                status_seen[i] = 0;
            end
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [7:0] index, logic [15:0] data);
            case (index)
                CFG_OWN_NODE_ID:        own_id = data;
                CFG_UPDATES_ENABLED:    upd_en = data[0];
                CFG_TRACK_EUI:          track = data[0];
                CFG_REPORT_DESTINATION: dest = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Build a result showing one entry, or blank fields when slot is negative
        function nbr_result_t entry_view(int slot, status_t st);
            nbr_result_t r;
            r = '0;
            r.status = st;
            r.dest = dest;
            if (slot >= 0)
            begin
                r.index = slot[3:0];
                r.short_id = tbl_id[slot];
                r.lqi = tbl_lqi[slot];
                r.rssi = tbl_rssi[slot];
                r.eui = tbl_eui[slot];
            end
            return r;
        endfunction

        // Apply one accepted item to the table and queue the result it causes
        function void note_input(op_t op, logic [15:0] sender, logic mgmt, logic rsp,
                                 logic [7:0] lqi, logic signed [7:0] rssi, logic [63:0] eui);
            nbr_result_t r;
            int slot;
            int i;
            slot = -1;
            if (op == OP_LOOKUP)
            begin
                // scan downward so the lowest matching valid entry wins
                for (i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (tbl_id[i] != NULL_SHORT_ID && tbl_eui[i] == eui)
                        slot = i;
                end
                r = entry_view(slot, (slot < 0) ? ST_MISS : ST_HIT);
            end
            else if (!mgmt || sender == own_id || sender == NULL_SHORT_ID)
            begin
                r = entry_view(-1, ST_IGNORED);
            end
            else
            begin
                for (i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (tbl_id[i] == sender)
                        slot = i;
                end
                if (slot < 0)
                begin
                    for (i = ENTRIES - 1; i >= 0; i--)
                    begin
                        if (tbl_id[i] == NULL_SHORT_ID)
                            slot = i;
                    end
                end
                if (slot < 0)
                begin
                    r = entry_view(-1, ST_FULL);
                end
                else
                begin
                    tbl_id[slot] = sender;
                    tbl_lqi[slot] = lqi;
                    tbl_rssi[slot] = rssi;
                    if (track && rsp)
                        tbl_eui[slot] = eui;
                    r = entry_view(slot, ST_RECORDED);
                    r.req = (tbl_eui[slot] == '0);
                    r.upd = upd_en;
                end
            end
            status_seen[r.status]++;
            expected_results.push_back(r);
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic [2:0] st, logic [3:0] idx, logic [15:0] short_id,
                                   logic [7:0] lqi, logic [7:0] rssi, logic [63:0] eui,
                                   logic req, logic upd, logic [15:0] to);
            nbr_result_t exp;
            string bad;
            bad = "";
            checked++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected: status=%0d idx=%0d",
                             checked, st, idx);
                return;
            end
            exp = expected_results.pop_front();
            if (st !== exp.status) bad = {bad, " status"};
            if (idx !== exp.index) bad = {bad, " entry_index"};
            if (short_id !== exp.short_id) bad = {bad, " entry_short_id"};
            if (lqi !== exp.lqi) bad = {bad, " entry_lqi"};
            if (rssi !== exp.rssi) bad = {bad, " entry_rssi"};
            if (eui !== exp.eui) bad = {bad, " entry_eui"};
            if (req !== exp.req) bad = {bad, " request_eui"};
            if (upd !== exp.upd) bad = {bad, " send_update"};
            if (to !== exp.dest) bad = {bad, " send_to"};
            if (bad.len() > 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("result %0d wrong in:%s", checked, bad);
                    $display("exp st=%0d idx=%0d id=%h lqi=%0d rssi=%0d eui=%h req=%b upd=%b to=%h",
                             exp.status, exp.index, exp.short_id, exp.lqi, exp.rssi, exp.eui,
                             exp.req, exp.upd, exp.dest);
                    $display("act st=%0d idx=%0d id=%h lqi=%0d rssi=%0d eui=%h req=%b upd=%b to=%h",
                             st, idx, short_id, lqi, $signed(rssi), eui, req, upd, to);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               opcode;
    logic [15:0]        sender_id;
    logic               is_mgmt_packet;
    logic               is_addr_response;
    logic [7:0]         link_quality;
    logic signed [7:0]  signal_strength;
    logic [63:0]        long_address;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic [3:0]         entry_index;
    logic [15:0]        entry_short_id;
    logic [7:0]         entry_lqi;
    logic signed [7:0]  entry_rssi;
    logic [63:0]        entry_eui;
    logic               request_eui;
    logic               send_update;
    logic [15:0]        send_to;

    typedef link_table_scoreboard_t #(.ENTRIES(NUM_ENTRIES)) scoreboard_t;
    scoreboard_t sb = new();

    int items_sent;
    int results_seen;
    int cfg_writes;
    bit src_burst;
    bit sink_burst;

    neighbor_link_quality_table #(
        .TABLE_ENTRIES(NUM_ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .sender_id(sender_id),
        .is_mgmt_packet(is_mgmt_packet),
        .is_addr_response(is_addr_response),
        .link_quality(link_quality),
        .signal_strength(signal_strength),
        .long_address(long_address),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .entry_index(entry_index),
        .entry_short_id(entry_short_id),
        .entry_lqi(entry_lqi),
        .entry_rssi(entry_rssi),
        .entry_eui(entry_eui),
        .request_eui(request_eui),
        .send_update(send_update),
        .send_to(send_to)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Idle length before a transfer: mostly none or short, sometimes long
    function automatic int pick_gap(bit burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(op_t op, logic [15:0] sender, logic mgmt, logic rsp,
                             logic [7:0] lqi, logic signed [7:0] rssi, logic [63:0] eui);
        int gap;
        gap = pick_gap(src_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode <= op;
        sender_id <= sender;
        is_mgmt_packet <= mgmt;
        is_addr_response <= rsp;
        link_quality <= lqi;
        signal_strength <= rssi;
        long_address <= eui;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_input(op, sender, mgmt, rsp, lqi, rssi, eui);
        items_sent++;
        if (items_sent % 50 == 0)
            src_burst = ($urandom_range(0, 2) == 0);
    endtask

    // Random item, steered toward entries the table already holds
    task automatic send_random();
        op_t op;
        logic [15:0] sender;
        logic [63:0] eui;
        int roll;
        int slot;
        slot = $urandom_range(0, NUM_ENTRIES - 1);
        sender = 16'($urandom);
        eui = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
        begin
            op = OP_LOOKUP;
            roll = $urandom_range(0, 9);
            if (roll < 6)
                eui = sb.tbl_eui[slot];
            else if (roll < 8)
                eui = '0;
        end
        else
        begin
            op = OP_PACKET;
            roll = $urandom_range(0, 99);
            if (roll < 60)
                sender = sb.tbl_id[slot];
            else if (roll < 68)
                sender = sb.own_id;
            else if (roll < 74)
                sender = NULL_SHORT_ID;
            roll = $urandom_range(0, 9);
            if (roll == 0)
                eui = '0;
            else if (roll == 1)
                eui = sb.tbl_eui[$urandom_range(0, NUM_ENTRIES - 1)];
        end
        send_item(op, sender, $urandom_range(0, 9) != 0, $urandom_range(0, 2) != 0,
                  8'($urandom), 8'($urandom), eui);
    endtask

    // Drop valid and let every expected result come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // One register write transfer
    task automatic write_reg(logic [7:0] index, logic [15:0] data);
        @(negedge clk);
        cfg_index <= index;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(index, data);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write all four registers plus one unused index; junk in the upper bits of flags
    task automatic set_config(logic [15:0] own, logic upd, logic track, logic [15:0] dest);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(CFG_OWN_NODE_ID, own);
        write_reg(CFG_UPDATES_ENABLED, {junk[15:1], upd});
        write_reg(8'($urandom_range(CFG_FIRST_UNUSED, 8'hFF)), 16'($urandom));
        junk = 16'($urandom);
        write_reg(CFG_TRACK_EUI, {junk[15:1], track});
        write_reg(CFG_REPORT_DESTINATION, dest);
    endtask

    // Result side: random stalls, long hold-offs at two points
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
                stall = HOLD_CYCLES;
            else
                stall = pick_gap(sink_burst);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(status, entry_index, entry_short_id, entry_lqi, entry_rssi,
                            entry_eui, request_eui, send_update, send_to);
            results_seen++;
            if (results_seen % 40 == 0)
                sink_burst = ($urandom_range(0, 2) == 0);
        end
    end

    // End the run when no transfer happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transfer for %0d cycles, %0d results outstanding", IDLE_LIMIT,
                 sb.pending());
        $display("neighbor_link_quality_table: mismatch");
        $finish;
    end

    // Reset, directed items, then random phases under changing settings
    initial
    begin : stimulus
        int phase;
        int n;
        int k;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_PACKET;
        sender_id = '0;
        is_mgmt_packet = 1'b0;
        is_addr_response = 1'b0;
        link_quality = '0;
        signal_strength = '0;
        long_address = '0;
        items_sent = 0;
        results_seen = 0;
        cfg_writes = 0;
        src_burst = 1'b0;
        sink_burst = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty-table lookup, ignore rules, field extremes, fill, full table
        send_item(OP_LOOKUP, 16'h0000, 1'b1, 1'b0, 8'h00, 8'sh00, 64'h0);
        send_item(OP_PACKET, 16'h0001, 1'b0, 1'b1, 8'h10, 8'sh10, 64'h1234);
        send_item(OP_PACKET, 16'h0000, 1'b1, 1'b1, 8'h20, 8'sh20, 64'h5678);
        send_item(OP_PACKET, NULL_SHORT_ID, 1'b1, 1'b1, 8'h30, 8'sh30, 64'h9ABC);
        send_item(OP_PACKET, 16'h0001, 1'b1, 1'b0, 8'h00, 8'sh80, 64'hDEAD_BEEF);
        send_item(OP_PACKET, 16'hFFFE, 1'b1, 1'b1, 8'hFF, 8'sh7F, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_LOOKUP, 16'h0000, 1'b0, 1'b0, 8'h00, 8'sh00, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_LOOKUP, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 8'shFF, 64'h0);
        send_item(OP_PACKET, 16'h0001, 1'b1, 1'b1, 8'h55, 8'shAA, 64'h8000_0000_0000_0001);
        send_item(OP_PACKET, 16'hFFFE, 1'b1, 1'b1, 8'hAA, 8'sh55, 64'h0);
        for (k = 2; k < NUM_ENTRIES; k++)
        begin
            send_item(OP_PACKET, 16'h1000 + 16'(k) * 16'h0111, 1'b1, k[0], 8'($urandom),
                      8'($urandom), {$urandom, $urandom});
        end
        send_item(OP_PACKET, 16'hABCD, 1'b1, 1'b1, 8'h01, 8'sh01, 64'h1);
        send_item(OP_PACKET, 16'h1555, 1'b1, 1'b1, 8'h02, 8'sh02, 64'h0123_4567_89AB_CDEF);
        drain();

        // Random phases; settings cover the extremes of every register
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: set_config(sb.tbl_id[3], 1'b1, 1'b1, 16'hFFFF);
                1: set_config(16'hFFFF, 1'b0, 1'b0, 16'($urandom));
                2: set_config(16'($urandom), 1'b1, 1'b0, 16'h0000);
                3: set_config(16'h0000, 1'b1, 1'b1, 16'($urandom));
                4: set_config(sb.tbl_id[$urandom_range(0, NUM_ENTRIES - 1)],
                              1'($urandom_range(0, 1)), 1'b1, 16'($urandom));
                default: set_config(16'($urandom), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)), 16'($urandom));
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_random();
            end
            drain();
        end

        // Catch any stray result after the last one
        repeat (2 * NUM_ENTRIES) @(posedge clk);

        $display("%0d items, %0d results checked over %0d register writes and %0d settings",
                 items_sent, sb.checked, cfg_writes, PHASES + 1);
        $display("recorded %0d, ignored %0d, table full %0d, lookup hit %0d, lookup miss %0d",
                 sb.status_seen[ST_RECORDED], sb.status_seen[ST_IGNORED],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_HIT], sb.status_seen[ST_MISS]);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("neighbor_link_quality_table: match");
        end
        else
        begin
            $display("%0d bad results, %0d never arrived", sb.mismatches, sb.pending());
            $display("neighbor_link_quality_table: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/nlqt_pkg.sv
rtl/core/nlqt_cell.sv
rtl/core/neighbor_link_quality_table.sv
tb/neighbor_link_quality_table_tb.sv
